// ===== rtl/lidar_frame_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Lidar frame parser assertion macros
// Concurrent assertion helpers shared by the parser modules.
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_PARSER_DEFINES_SVH
`define LIDAR_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clk_i edge while rst_ni is high.
`define LFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clk_i edge, reset included.
`define LFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LFP_ASSERT(lbl, prop, msg)
`define LFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Lidar frame parser package
// Types and constants shared by the controller, datapath and divider.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int unsigned SUM_W   = 22;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned OFF_W   = 6;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned STEP_W  = $clog2(SUM_W);

  localparam logic [7:0] SYNC_FIRST  = 8'hFA;
  localparam logic [7:0] SYNC_SECOND = 8'hA0;

  // Byte offsets within one packet.
  localparam logic [OFF_W-1:0] OFF_HDR0       = 6'd0;
  localparam logic [OFF_W-1:0] OFF_HDR1       = 6'd1;
  localparam logic [OFF_W-1:0] OFF_SPD_LO     = 6'd2;
  localparam logic [OFF_W-1:0] OFF_SPD_HI     = 6'd3;
  localparam logic [OFF_W-1:0] OFF_FIRST_DATA = 6'd2;
  localparam logic [OFF_W-1:0] OFF_READ_START = 6'd4;
  localparam logic [OFF_W-1:0] OFF_READ_END   = 6'd40;
  localparam logic [OFF_W-1:0] OFF_LAST       = 6'd41;

  // Byte position within one six-byte reading.
  localparam logic [SLOT_W-1:0] K_RANGE_HI = 3'd3;
  localparam logic [SLOT_W-1:0] K_LAST     = 3'd5;

  localparam logic [ANGLE_W-1:0] ANGLE_STEP = 9'd6;

  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    S_HUNT,
    S_SYNC,
    S_FRAME,
    S_DIV
  } lfp_state_e;

  typedef struct packed {
    logic frame_start;
    logic frame_byte;
    logic div_start;
    logic load_sum;
  } lfp_cmd_t;

  typedef struct packed {
    logic is_sync_first;
    logic is_sync_second;
    logic last_byte;
    logic div_done;
    logic out_free;
  } lfp_sts_t;

endpackage

// ===== rtl/lfp_div.sv =====
// ----------------------------------------------------------------------------
// Lidar frame parser divider
// Restoring divider, one quotient bit per cycle, for the speed average.
// ----------------------------------------------------------------------------
module lfp_div
  import lfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  localparam logic [STEP_W-1:0] STEPS_M1 = STEP_W'(SUM_W - 1);

  logic [SUM_W-1:0]  dq_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [CNT_W-1:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q, dq_q[SUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEPS_M1;
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[SUM_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q[QUO_W-1:0];

endmodule

// ===== rtl/lfp_datapath.sv =====
// ----------------------------------------------------------------------------
// Lidar frame parser datapath
// Packet position counters, header check, speed sum, reading assembly and
// the output register.
// ----------------------------------------------------------------------------
`include "lidar_frame_parser_defines.svh"

module lfp_datapath
  import lfp_pkg::*;
#(
  parameter int unsigned PACKETS_PER_FRAME = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         data_byte_i,
  input  logic               out_ready_i,
  input  lfp_cmd_t           cmd_i,
  output lfp_sts_t           sts_o,
  output logic               out_valid_o,
  output logic               kind_o,
  output logic [ANGLE_W-1:0] angle_index_o,
  output logic [15:0]        range_mm_o,
  output logic [15:0]        intensity_o,
  output logic [15:0]        avg_speed_o,
  output logic [CNT_W-1:0]   good_packets_o,
  output logic               no_good_packets_o
);

  localparam logic [CNT_W-1:0] LAST_PKT = CNT_W'(PACKETS_PER_FRAME - 1);

  logic [OFF_W-1:0]   off_q, off_d;
  logic [CNT_W-1:0]   pkt_q, pkt_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]  k_q, k_d;
  logic [ANGLE_W-1:0] base_q, base_d;
  logic               pvalid_q, pvalid_d;
  logic [7:0]         spd_lo_q, spd_lo_d;
  logic [23:0]        held_q, held_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [ANGLE_W-1:0] angle_q, angle_d;
  logic [15:0]        range_q, range_d;
  logic [15:0]        inten_q, inten_d;
  logic [15:0]        avg_q, avg_d;
  logic [CNT_W-1:0]   good_q, good_d;
  logic               none_q, none_d;

  logic               div_done;
  logic [QUO_W-1:0]   quotient;

  lfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    off_d       = off_q;
    pkt_d       = pkt_q;
    slot_d      = slot_q;
    k_d         = k_q;
    base_d      = base_q;
    pvalid_d    = pvalid_q;
    spd_lo_d    = spd_lo_q;
    held_d      = held_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    kind_d      = kind_q;
    angle_d     = angle_q;
    range_d     = range_q;
    inten_d     = inten_q;
    avg_d       = avg_q;
    good_d      = good_q;
    none_d      = none_q;

    if (cmd_i.frame_start) begin
      off_d    = OFF_FIRST_DATA;
      pkt_d    = '0;
      base_d   = '0;
      pvalid_d = 1'b1;
      sum_d    = '0;
      cnt_d    = '0;
    end

    if (cmd_i.frame_byte) begin
      unique case (off_q)
        OFF_HDR0: pvalid_d = (data_byte_i == SYNC_FIRST);
        OFF_HDR1: begin
          if (data_byte_i != (SYNC_SECOND + {2'b00, pkt_q})) begin
            pvalid_d = 1'b0;
          end
        end
        OFF_SPD_LO: spd_lo_d = data_byte_i;
        OFF_SPD_HI: begin
          if (pvalid_q) begin
            sum_d = sum_q + SUM_W'({data_byte_i, spd_lo_q});
            cnt_d = cnt_q + 1'b1;
          end
          k_d    = '0;
          slot_d = '0;
        end
        default: begin
          if (off_q >= OFF_READ_START && off_q < OFF_READ_END) begin
            case (k_q)
              3'd0: held_d[7:0]   = data_byte_i;
              3'd1: held_d[15:8]  = data_byte_i;
              3'd2: held_d[23:16] = data_byte_i;
              default: begin
                if (k_q == K_RANGE_HI && pvalid_q) begin
                  out_valid_d = 1'b1;
                  kind_d      = KIND_READING;
                  angle_d     = base_q + {{(ANGLE_W-SLOT_W){1'b0}}, slot_q};
                  range_d     = {data_byte_i, held_q[23:16]};
                  inten_d     = held_q[15:0];
                  avg_d       = '0;
                  good_d      = '0;
                  none_d      = 1'b0;
                end
              end
            endcase
            if (k_q == K_LAST) begin
              k_d    = '0;
              slot_d = slot_q + 1'b1;
            end else begin
              k_d = k_q + 1'b1;
            end
          end
        end
      endcase

      if (off_q == OFF_LAST) begin
        off_d  = '0;
        pkt_d  = pkt_q + 1'b1;
        base_d = base_q + ANGLE_STEP;
      end else begin
        off_d = off_q + 1'b1;
      end
    end

    if (cmd_i.load_sum) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_SUMMARY;
      angle_d     = '0;
      range_d     = '0;
      inten_d     = '0;
      avg_d       = (cnt_q == '0) ? '0 : quotient;
      good_d      = cnt_q;
      none_d      = (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      pkt_q       <= '0;
      slot_q      <= '0;
      k_q         <= '0;
      base_q      <= '0;
      pvalid_q    <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      off_q       <= off_d;
      pkt_q       <= pkt_d;
      slot_q      <= slot_d;
      k_q         <= k_d;
      base_q      <= base_d;
      pvalid_q    <= pvalid_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spd_lo_q <= spd_lo_d;
    held_q   <= held_d;
    kind_q   <= kind_d;
    angle_q  <= angle_d;
    range_q  <= range_d;
    inten_q  <= inten_d;
    avg_q    <= avg_d;
    good_q   <= good_d;
    none_q   <= none_d;
  end

  always_comb begin
    sts_o.is_sync_first  = (data_byte_i == SYNC_FIRST);
    sts_o.is_sync_second = (data_byte_i == SYNC_SECOND);
    sts_o.last_byte      = (off_q == OFF_LAST) && (pkt_q == LAST_PKT);
    sts_o.div_done       = div_done;
    sts_o.out_free       = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign angle_index_o     = angle_q;
  assign range_mm_o        = range_q;
  assign intensity_o       = inten_q;
  assign avg_speed_o       = avg_q;
  assign good_packets_o    = good_q;
  assign no_good_packets_o = none_q;

  `LFP_ASSERT(a_off_in_packet, off_q <= OFF_LAST, "packet offset out of range")
  `LFP_ASSERT(a_summary_flag, out_valid_q && kind_q |-> none_q == (good_q == '0),
              "summary flag disagrees with good count")
  `LFP_ASSERT(a_reading_clean, out_valid_q && !kind_q |-> avg_q == '0 && good_q == '0,
              "reading carries summary fields")

endmodule

// ===== rtl/lfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lidar frame parser controller
// Sync hunt, frame tracking and the end-of-frame divide sequence.
// ----------------------------------------------------------------------------
`include "lidar_frame_parser_defines.svh"

module lfp_ctrl
  import lfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  lfp_sts_t sts_i,
  output logic     in_ready_o,
  output lfp_cmd_t cmd_o
);

  lfp_state_e state_q, state_d;
  logic       in_acc;

  assign in_acc = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_HUNT: begin
        if (in_acc && sts_i.is_sync_first) begin
          state_d = S_SYNC;
        end
      end
      S_SYNC: begin
        // A mismatching second byte is dropped, not rescanned as a first sync.
        if (in_acc) begin
          state_d = sts_i.is_sync_second ? S_FRAME : S_HUNT;
        end
      end
      S_FRAME: begin
        if (in_acc && sts_i.last_byte) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done && sts_i.out_free) begin
          state_d = S_HUNT;
        end
      end
      default: state_d = S_HUNT;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q != S_DIV) && sts_i.out_free;
    cmd_o.frame_start = in_acc && (state_q == S_SYNC) && sts_i.is_sync_second;
    cmd_o.frame_byte  = in_acc && (state_q == S_FRAME);
    cmd_o.div_start   = in_acc && (state_q == S_FRAME) && sts_i.last_byte;
    cmd_o.load_sum    = (state_q == S_DIV) && sts_i.div_done && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  `LFP_ASSERT_ALWAYS(a_no_take_in_div, state_q == S_DIV |-> !in_ready_o,
                     "word accepted during divide")
  `LFP_ASSERT(a_last_to_div, in_acc && state_q == S_FRAME && sts_i.last_byte |=> state_q == S_DIV,
              "last frame word did not start divide")
  `LFP_ASSERT(a_sum_to_hunt, cmd_o.load_sum |=> state_q == S_HUNT,
              "summary not followed by hunt")

endmodule

// ===== rtl/lidar_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Lidar frame parser
// Byte-serial frame parser for a rotating range sensor.
// ----------------------------------------------------------------------------
// Input words arrive one byte at a time on data_byte_i under in_valid_i and
// in_ready_o. Results leave on the output channel under out_valid_o and
// out_ready_i, one field per port; kind_o tells a range reading from the
// end-of-frame summary.
// A reading appears in the output register the cycle after the word carrying
// its range high byte. The frame's last word starts a restoring divider that
// produces one quotient bit per cycle; the summary enters the output register
// once the divide is done and the register is free, and no input is taken
// until then. Otherwise throughput is one word per cycle while not stalled.
// A word is taken only while the output register is empty or being emptied,
// so while the receiver holds off a waiting result the input stalls as well.
// Reset puts the parser into sync hunting with the output register empty.
// ----------------------------------------------------------------------------
module lidar_frame_parser
  import lfp_pkg::*;
#(
  parameter int unsigned PACKETS_PER_FRAME = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [ANGLE_W-1:0] angle_index_o,
  output logic [15:0]        range_mm_o,
  output logic [15:0]        intensity_o,
  output logic [15:0]        avg_speed_o,
  output logic [CNT_W-1:0]   good_packets_o,
  output logic               no_good_packets_o
);

  lfp_cmd_t cmd;
  lfp_sts_t sts;

  lfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lfp_datapath #(
    .PACKETS_PER_FRAME (PACKETS_PER_FRAME)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .data_byte_i       (data_byte_i),
    .out_ready_i       (out_ready_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .angle_index_o     (angle_index_o),
    .range_mm_o        (range_mm_o),
    .intensity_o       (intensity_o),
    .avg_speed_o       (avg_speed_o),
    .good_packets_o    (good_packets_o),
    .no_good_packets_o (no_good_packets_o)
  );

endmodule
